>>> rtl/chbd_pkg.sv
`default_nettype none
package chbd_pkg;
	localparam int MaxCodeLen = 16;
	localparam int MaxSymbols = 256;

	typedef enum logic [1:0] {
		OP_LOAD_COUNT = 2'd0,
		OP_APPEND     = 2'd1,
		OP_BUILD      = 2'd2,
		OP_DECODE     = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_TOO_FEW   = 3'd1,
		ST_BAD       = 3'd2,
		ST_TOO_MANY  = 3'd3,
		ST_NOT_BUILT = 3'd4,
		ST_NO_CODE   = 3'd5,
		ST_FULL      = 3'd6
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic walk;
		logic check;
		logic fetch;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_busy;
		logic is_build;
		logic hit;
		logic walk_last;
	} sts_t;
endpackage
`default_nettype wire

>>> rtl/chbd_in_if.sv
`default_nettype none
interface chbd_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [4:0] code_length;
	logic [7:0] code_count;
	logic [7:0] symbol_in;
	logic       bit_req;

	modport source (output valid, op, code_length, code_count, symbol_in, bit_req,
		input ready);
	modport sink (input valid, op, code_length, code_count, symbol_in, bit_req,
		output ready);
endinterface
`default_nettype wire

>>> rtl/chbd_out_if.sv
`default_nettype none
interface chbd_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic       symbol_ready;
	logic [7:0] symbol;

	modport source (output valid, status, symbol_ready, symbol, input ready);
	modport sink (input valid, status, symbol_ready, symbol, output ready);
endinterface
`default_nettype wire

>>> rtl/chbd_ram.sv
`default_nettype none
module chbd_ram #(
	parameter int Width = 8,
	parameter int Depth = 512
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

>>> rtl/chbd_ctrl.sv
`default_nettype none
module chbd_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire chbd_pkg::sts_t sts,
	output chbd_pkg::cmd_t     cmd
);
	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_WALK  = 4'b0010,
		S_CHECK = 4'b0100,
		S_FETCH = 4'b1000
	} state_t;

	state_t state_q, state_d;

	assign in_ready   = (state_q == S_IDLE) && !sts.out_busy;
	assign cmd.accept = in_ready && in_valid;
	assign cmd.walk   = (state_q == S_WALK);
	assign cmd.check  = (state_q == S_CHECK);
	assign cmd.fetch  = (state_q == S_FETCH);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd.accept && sts.is_build) begin
					state_d = S_WALK;
				end else if (cmd.accept && sts.hit) begin
					state_d = S_FETCH;
				end
			end
			S_WALK: begin
				if (sts.walk_last) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: state_d = S_IDLE;
			S_FETCH: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !cmd.accept) else $error("accept while busy");
	a_walk_to_check: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK && sts.walk_last) |=> (state_q == S_CHECK))
		else $error("walk did not end in check");
	a_fetch_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FETCH) |=> (state_q == S_IDLE)) else $error("fetch overran");
endmodule
`default_nettype wire

>>> rtl/chbd_dp.sv
`default_nettype none
module chbd_dp (
	input  wire logic      clk,
	input  wire logic      arst_n,
	chbd_in_if.sink        in_ch,
	chbd_out_if.source     out_ch,
	input  wire chbd_pkg::cmd_t cmd,
	output chbd_pkg::sts_t sts
);
	// staging and active tables
	logic [7:0]  stc_q [16];
	logic [7:0]  act_q [16];
	logic [15:0] fc_q [16];
	logic [8:0]  off_q [16];
	logic [8:0]  stot_q;
	logic        bank_q;
	logic        built_q;
	logic [4:0]  longest_q;
	logic [15:0] lastc_q;
	logic [15:0] rc_q;
	logic [4:0]  rl_q;

	// build walk
	logic [3:0]  wl_q;
	logic [16:0] code_q;
	logic [11:0] k_q;
	logic [11:0] tot_q;
	logic        ovf_q;
	logic [17:0] ovf_idx_q;
	logic [4:0]  wlong_q;
	logic [15:0] wlast_q;
	logic [15:0] nf_q [16];
	logic [8:0]  no_q [16];

	// output register
	logic        ov_q;
	logic [2:0]  ost_q;
	logic        ordy_q;
	logic [7:0]  osym_q;

	logic [8:0]  ram_waddr, ram_raddr;
	logic [7:0]  ram_rdata;
	logic        ram_we;

	chbd_ram #(.Width(8), .Depth(2 * chbd_pkg::MaxSymbols)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (in_ch.symbol_in),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	chbd_pkg::op_t op;
	assign op = chbd_pkg::op_t'(in_ch.op);

	// decode path
	logic [4:0]  n;
	logic [3:0]  di;
	logic [16:0] p, fc17, up17, diff;
	logic [4:0]  sh;
	logic        dec_miss, dec_hit;
	assign n    = rl_q + 5'd1;
	assign di   = rl_q[3:0];
	assign p    = {rc_q, in_ch.bit_req};
	assign fc17 = {1'b0, fc_q[di]};
	assign sh   = longest_q - n;
	assign up17 = {1'b0, lastc_q >> sh};
	assign diff = p - fc17;
	assign dec_miss = (n > longest_q) || (p < fc17) || (p > up17);
	assign dec_hit  = !dec_miss && (diff < {9'd0, act_q[di]});
	assign ram_raddr = {bank_q, off_q[di][7:0] + diff[7:0]};

	logic full;
	assign full      = stot_q[8];
	assign ram_we    = cmd.accept && op == chbd_pkg::OP_APPEND && !full;
	assign ram_waddr = {~bank_q, stot_q[7:0]};

	assign sts.out_busy  = ov_q && !out_ch.ready;
	assign sts.is_build  = (op == chbd_pkg::OP_BUILD);
	assign sts.hit       = (op == chbd_pkg::OP_DECODE) && built_q && dec_hit;
	assign sts.walk_last = (wl_q == 4'd15);

	// walk step
	logic [7:0]  wc;
	logic [16:0] space, csum;
	logic        step_ovf;
	assign wc       = stc_q[wl_q];
	assign space    = 17'd1 << ({1'b0, wl_q} + 5'd1);
	assign csum     = code_q + {9'd0, wc};
	assign step_ovf = (wc != 8'd0) && (csum > space);

	// build verdict
	chbd_pkg::status_t bst;
	always_comb begin
		if (ovf_q && ovf_idx_q <= {9'd0, stot_q}) begin
			bst = chbd_pkg::ST_BAD;
		end else if (ovf_q || tot_q > {3'd0, stot_q}) begin
			bst = chbd_pkg::ST_TOO_FEW;
		end else if (tot_q >= 12'd2 && {3'd0, stot_q} > tot_q) begin
			bst = chbd_pkg::ST_TOO_MANY;
		end else begin
			bst = chbd_pkg::ST_OK;
		end
	end

	// immediate result
	chbd_pkg::status_t ist;
	always_comb begin
		ist = chbd_pkg::ST_OK;
		case (op)
			chbd_pkg::OP_APPEND: if (full) ist = chbd_pkg::ST_FULL;
			chbd_pkg::OP_DECODE: begin
				if (!built_q) begin
					ist = chbd_pkg::ST_NOT_BUILT;
				end else if (dec_miss) begin
					ist = chbd_pkg::ST_NO_CODE;
				end
			end
			default: ist = chbd_pkg::ST_OK;
		endcase
	end

	logic simple_load;
	assign simple_load = cmd.accept && !sts.is_build && !sts.hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				stc_q[i] <= '0;
				act_q[i] <= '0;
				fc_q[i]  <= '0;
				off_q[i] <= '0;
			end
			stot_q    <= '0;
			bank_q    <= 1'b0;
			built_q   <= 1'b0;
			longest_q <= '0;
			lastc_q   <= '0;
			rc_q      <= '0;
			rl_q      <= '0;
			wl_q      <= '0;
			ov_q      <= 1'b0;
		end else begin
			if (cmd.accept) begin
				case (op)
					chbd_pkg::OP_LOAD_COUNT: begin
						if (in_ch.code_length >= 5'd1 && in_ch.code_length <= 5'd16) begin
							stc_q[4'(in_ch.code_length - 5'd1)] <= in_ch.code_count;
						end
					end
					chbd_pkg::OP_APPEND: if (!full) stot_q <= stot_q + 9'd1;
					chbd_pkg::OP_BUILD: wl_q <= '0;
					chbd_pkg::OP_DECODE: begin
						if (built_q && !dec_miss) begin
							if (dec_hit) begin
								rc_q <= '0;
								rl_q <= '0;
							end else begin
								rc_q <= p[15:0];
								rl_q <= n;
							end
						end
					end
					default: ;
				endcase
			end
			if (cmd.walk) begin
				wl_q <= wl_q + 4'd1;
			end
			if (cmd.check && bst == chbd_pkg::ST_OK) begin
				for (int i = 0; i < 16; i++) begin
					act_q[i] <= stc_q[i];
					fc_q[i]  <= nf_q[i];
					off_q[i] <= no_q[i];
					stc_q[i] <= '0;
				end
				longest_q <= wlong_q;
				lastc_q   <= wlast_q;
				bank_q    <= ~bank_q;
				stot_q    <= '0;
				built_q   <= 1'b1;
				rc_q      <= '0;
				rl_q      <= '0;
			end
			if (simple_load || cmd.check || cmd.fetch) begin
				ov_q <= 1'b1;
			end else if (out_ch.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// walk accumulators and result payload
	always_ff @(posedge clk) begin
		if (cmd.accept && sts.is_build) begin
			code_q  <= '0;
			k_q     <= '0;
			tot_q   <= '0;
			ovf_q   <= 1'b0;
			wlong_q <= '0;
			wlast_q <= '0;
		end else if (cmd.walk) begin
			tot_q <= tot_q + {4'd0, wc};
			if (!ovf_q) begin
				nf_q[wl_q] <= code_q[15:0];
				no_q[wl_q] <= k_q[8:0];
				if (step_ovf) begin
					ovf_q     <= 1'b1;
					ovf_idx_q <= {6'd0, k_q} + {1'b0, space} - {1'b0, code_q};
				end else begin
					if (wc != 8'd0) begin
						wlong_q <= {1'b0, wl_q} + 5'd1;
						wlast_q <= 16'(csum - 17'd1);
					end
					k_q    <= k_q + {4'd0, wc};
					code_q <= {csum[15:0], 1'b0};
				end
			end
		end
		if (simple_load) begin
			ost_q  <= ist;
			ordy_q <= 1'b0;
			osym_q <= '0;
		end else if (cmd.check) begin
			ost_q  <= bst;
			ordy_q <= 1'b0;
			osym_q <= '0;
		end else if (cmd.fetch) begin
			ost_q  <= chbd_pkg::ST_OK;
			ordy_q <= 1'b1;
			osym_q <= ram_rdata;
		end
	end

	assign out_ch.valid        = ov_q;
	assign out_ch.status       = ost_q;
	assign out_ch.symbol_ready = ordy_q;
	assign out_ch.symbol       = osym_q;
endmodule
`default_nettype wire

>>> rtl/canonical_huffman_bit_decoder.sv
// latency: load, append and decode-bit items give their result 1 cycle after the transfer,
//   a decode bit that completes a code 2 cycles (symbol memory read port)
// build: 18 cycles, a walk over the 16 code lengths one per cycle, then the check and commit
// throughput: one item per cycle while the result side keeps up, except build and symbol hits
// reset: arst_n asynchronous active low; no code built, staging empty, bank 0 active
`default_nettype none
module canonical_huffman_bit_decoder (
	input wire logic   clk,
	input wire logic   arst_n,
	chbd_in_if.sink    in_ch,
	chbd_out_if.source out_ch
);
	// command and status between the sequencer and the tables
	chbd_pkg::cmd_t cmd;
	chbd_pkg::sts_t sts;

	// sequencer: idle, length walk, build check, symbol fetch
	chbd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// staging, active code tables, symbol memory and the result register
	chbd_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cmd    (cmd),
		.sts    (sts)
	);
endmodule
`default_nettype wire

>>> bench/canonical_huffman_bit_decoder_test.sv
`default_nettype none
module canonical_huffman_bit_decoder_test;
	import chbd_pkg::*;

	logic clk;
	logic arst_n;

	chbd_in_if  in_ch();
	chbd_out_if out_ch();

	canonical_huffman_bit_decoder DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	// one decoder item
	typedef struct packed {
		op_t        op;
		logic [4:0] code_length;
		logic [7:0] code_count;
		logic [7:0] symbol_in;
		logic       bit_req;
	} item_t;

	// one decoder result
	typedef struct packed {
		status_t    status;
		logic       symbol_ready;
		logic [7:0] symbol;
	} outcome_t;

	// directed row: item, whether the outcome is typed in, the outcome
	typedef struct packed {
		item_t    it;
		logic     fixed;
		outcome_t res;
	} row_t;

	// predictor state
	logic [7:0]  pr_staged [16];
	logic [7:0]  pr_bank [512];
	int unsigned pr_staged_total;
	logic        pr_active_bank;
	logic        pr_built;
	logic [7:0]  pr_counts [16];
	int unsigned pr_first [16];
	int unsigned pr_offset [16];
	int unsigned pr_longest;
	int unsigned pr_last_code;
	int unsigned pr_run_code;
	int unsigned pr_run_len;

	outcome_t expected_q[$];
	item_t    stim_q[$];
	logic     typed_q[$];
	outcome_t typed_res_q[$];
	int       fail_count;
	int       sent_count;
	int       checked_count;
	int       symbol_count;
	int       in_idle_pct;
	int       out_stall_pct;
	longint   cycle_count;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic status_t build_code();
		int unsigned nf [16];
		int unsigned no [16];
		int unsigned code, k, total, longest, lastc, ovf_idx, c, space;
		logic ovf;
		code = 0;
		k = 0;
		total = 0;
		longest = 0;
		lastc = 0;
		ovf_idx = 0;
		ovf = 1'b0;
		for (int i = 0; i < 16; i++) begin
			nf[i] = 0;
			no[i] = 0;
			total += pr_staged[i];
		end
		for (int n = 1; n <= 16; n++) begin
			c = pr_staged[n-1];
			nf[n-1] = code;
			no[n-1] = k;
			if (c != 0) begin
				space = 1 << n;
				if (code + c > space) begin
					ovf = 1'b1;
					ovf_idx = k + (space - code);
					break;
				end
				longest = n;
				lastc = code + c - 1;
			end
			k += c;
			code = (code + c) << 1;
		end
		if (ovf && ovf_idx <= pr_staged_total)
			return ST_BAD;
		if (ovf || total > pr_staged_total)
			return ST_TOO_FEW;
		if (total >= 2 && pr_staged_total > total)
			return ST_TOO_MANY;
		for (int i = 0; i < 16; i++) begin
			pr_counts[i] = pr_staged[i];
			pr_first[i] = nf[i] & 16'hFFFF;
			pr_offset[i] = no[i] & 9'h1FF;
			pr_staged[i] = 8'd0;
		end
		pr_longest = longest;
		pr_last_code = lastc & 16'hFFFF;
		pr_active_bank = ~pr_active_bank;
		pr_staged_total = 0;
		pr_built = 1'b1;
		pr_run_code = 0;
		pr_run_len = 0;
		return ST_OK;
	endfunction

	function automatic outcome_t decode_item(item_t it);
		outcome_t r;
		int unsigned n, p, fc, upper;
		r = '{status: ST_OK, symbol_ready: 1'b0, symbol: 8'd0};
		case (it.op)
			OP_LOAD_COUNT: begin
				if (it.code_length >= 1 && it.code_length <= MaxCodeLen)
					pr_staged[it.code_length-1] = it.code_count;
			end
			OP_APPEND: begin
				if (pr_staged_total >= MaxSymbols)
					r.status = ST_FULL;
				else begin
					pr_bank[{~pr_active_bank, pr_staged_total[7:0]}] = it.symbol_in;
					pr_staged_total++;
				end
			end
			OP_BUILD: r.status = build_code();
			default: begin
				if (!pr_built)
					r.status = ST_NOT_BUILT;
				else begin
					n = pr_run_len + 1;
					p = ((pr_run_code << 1) | it.bit_req) & 17'h1FFFF;
					if (n > pr_longest || n > 16)
						r.status = ST_NO_CODE;
					else begin
						fc = pr_first[n-1];
						upper = pr_last_code >> (pr_longest - n);
						if (p < fc || p > upper)
							r.status = ST_NO_CODE;
						else if (p - fc < pr_counts[n-1]) begin
							r.symbol_ready = 1'b1;
							r.symbol = pr_bank[{pr_active_bank, 8'((pr_offset[n-1] + p - fc))}];
							pr_run_code = 0;
							pr_run_len = 0;
						end else begin
							pr_run_code = p & 16'hFFFF;
							pr_run_len = n;
						end
					end
				end
			end
		endcase
		return r;
	endfunction

	function automatic item_t mk(op_t op, int len, int cnt, int sym, int b);
		item_t it;
		it.op = op;
		it.code_length = 5'(len);
		it.code_count = 8'(cnt);
		it.symbol_in = 8'(sym);
		it.bit_req = 1'(b);
		return it;
	endfunction

	function automatic item_t noise_item();
		return mk(op_t'($urandom_range(0, 3)), $urandom_range(0, 31), $urandom_range(0, 255),
			$urandom_range(0, 255), $urandom_range(0, 1));
	endfunction

	// random code table with no oversubscribed length: counts, symbols, build, then a bit stream
	task automatic queue_table();
		int lens, cnt, total, room, nbits;
		total = 0;
		room = 2;
		lens = $urandom_range(1, 16);
		for (int n = 1; n <= 16; n++) begin
			cnt = 0;
			if (n <= lens && total < 40) begin
				cnt = $urandom_range(0, (room > 4) ? 4 : room);
				if (n == lens && cnt == room && $urandom_range(0, 1))
					cnt = room;
			end
			room = (room - cnt) * 2;
			if (room > 1024)
				room = 1024;
			total += cnt;
			stim_q.push_back(mk(OP_LOAD_COUNT, n, cnt, 0, 0));
		end
		// occasionally break the symbol total to hit the error paths
		if ($urandom_range(0, 9) == 0)
			total += $urandom_range(0, 1) ? 1 : -1;
		for (int i = 0; i < total && i < MaxSymbols; i++)
			stim_q.push_back(mk(OP_APPEND, 0, 0, $urandom_range(0, 255), 0));
		stim_q.push_back(mk(OP_BUILD, 0, 0, 0, 0));
		nbits = $urandom_range(10, 40);
		for (int i = 0; i < nbits; i++) begin
			if ($urandom_range(0, 19) == 0)
				stim_q.push_back(noise_item());
			else
				stim_q.push_back(mk(OP_DECODE, $urandom_range(0, 31), $urandom_range(0, 255),
					$urandom_range(0, 255), $urandom_range(0, 1)));
		end
	endtask

	// drive one item and wait for its transfer; valid stays high for the next item
	task automatic send_item(item_t it, logic typed, outcome_t res);
		typed_q.push_back(typed);
		typed_res_q.push_back(res);
		while (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.op <= it.op;
		in_ch.code_length <= it.code_length;
		in_ch.code_count <= it.code_count;
		in_ch.symbol_in <= it.symbol_in;
		in_ch.bit_req <= it.bit_req;
		do
			@(posedge clk);
		while (!in_ch.ready);
		sent_count++;
	endtask

	// result side: random stall and compare at every transfer
	always @(posedge clk) begin
		outcome_t e;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				checked_count++;
				if (expected_q.size() == 0) begin
					$error("result with nothing expected: status %0d", out_ch.status);
					fail_count++;
				end else begin
					e = expected_q.pop_front();
					if (out_ch.status !== e.status) begin
						$error("status expected %0d actual %0d", e.status, out_ch.status);
						fail_count++;
					end
					if (out_ch.symbol_ready !== e.symbol_ready) begin
						$error("symbol_ready expected %0d actual %0d", e.symbol_ready,
							out_ch.symbol_ready);
						fail_count++;
					end
					if (out_ch.symbol !== e.symbol) begin
						$error("symbol expected %0d actual %0d", e.symbol, out_ch.symbol);
						fail_count++;
					end
					if (e.symbol_ready)
						symbol_count++;
				end
			end
			out_ch.ready <= !(out_stall_pct != 0 && $urandom_range(0, 99) < out_stall_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > 400000) begin
			$display("canonical_huffman_bit_decoder_test failed");
			$finish;
		end
	end

	// expectations are added when the item is transferred, in order
	always @(posedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready) begin
			item_t    it;
			outcome_t e;
			outcome_t t;
			logic     typed;
			it.op = op_t'(in_ch.op);
			it.code_length = in_ch.code_length;
			it.code_count = in_ch.code_count;
			it.symbol_in = in_ch.symbol_in;
			it.bit_req = in_ch.bit_req;
			e = decode_item(it);
			typed = typed_q.pop_front();
			t = typed_res_q.pop_front();
			// typed-in rows are held against the predictor's view too
			if (typed) begin
				if (e !== t) begin
					$error("row status expected %0d predictor %0d", t.status, e.status);
					fail_count++;
				end
				e = t;
			end
			expected_q.push_back(e);
		end
	end

	initial begin
		row_t rows[$];
		outcome_t okr;
		okr = '{status: ST_OK, symbol_ready: 1'b0, symbol: 8'd0};
		fail_count = 0;
		sent_count = 0;
		checked_count = 0;
		symbol_count = 0;
		cycle_count = 0;
		in_idle_pct = 0;
		out_stall_pct = 0;
		pr_staged_total = 0;
		pr_active_bank = 1'b0;
		pr_built = 1'b0;
		pr_longest = 0;
		pr_last_code = 0;
		pr_run_code = 0;
		pr_run_len = 0;
		for (int i = 0; i < 16; i++) begin
			pr_staged[i] = 8'd0;
			pr_counts[i] = 8'd0;
			pr_first[i] = 0;
			pr_offset[i] = 0;
		end
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.op = OP_LOAD_COUNT;
		in_ch.code_length = '0;
		in_ch.code_count = '0;
		in_ch.symbol_in = '0;
		in_ch.bit_req = 1'b0;
		out_ch.ready = 1'b1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows: decode before a build, ignored lengths, errors, a small code
		rows.push_back('{mk(OP_DECODE, 0, 0, 0, 1), 1'b1,
			'{status: ST_NOT_BUILT, symbol_ready: 1'b0, symbol: 8'd0}});
		rows.push_back('{mk(OP_LOAD_COUNT, 0, 255, 0, 0), 1'b1, okr});
		rows.push_back('{mk(OP_LOAD_COUNT, 31, 255, 0, 0), 1'b1, okr});
		rows.push_back('{mk(OP_LOAD_COUNT, 1, 3, 0, 0), 1'b1, okr});
		// oversubscribed length one, no symbols staged
		rows.push_back('{mk(OP_BUILD, 0, 0, 0, 0), 1'b1,
			'{status: ST_TOO_FEW, symbol_ready: 1'b0, symbol: 8'd0}});
		rows.push_back('{mk(OP_APPEND, 0, 0, 8'hFF, 0), 1'b1, okr});
		rows.push_back('{mk(OP_APPEND, 0, 0, 8'h00, 0), 1'b1, okr});
		rows.push_back('{mk(OP_APPEND, 0, 0, 8'hA5, 0), 1'b1, okr});
		// oversubscription with enough symbols reads as bad structure
		rows.push_back('{mk(OP_BUILD, 0, 0, 0, 0), 1'b1,
			'{status: ST_BAD, symbol_ready: 1'b0, symbol: 8'd0}});
		rows.push_back('{mk(OP_LOAD_COUNT, 1, 1, 0, 0), 1'b1, okr});
		rows.push_back('{mk(OP_LOAD_COUNT, 2, 0, 0, 0), 1'b1, okr});
		rows.push_back('{mk(OP_LOAD_COUNT, 16, 1, 0, 0), 1'b1, okr});
		// two codes, three symbols
		rows.push_back('{mk(OP_BUILD, 0, 0, 0, 0), 1'b1,
			'{status: ST_TOO_MANY, symbol_ready: 1'b0, symbol: 8'd0}});
		rows.push_back('{mk(OP_LOAD_COUNT, 16, 0, 0, 0), 1'b1, okr});
		// single code, extra symbols ignored
		rows.push_back('{mk(OP_BUILD, 0, 0, 0, 0), 1'b1, okr});
		rows.push_back('{mk(OP_DECODE, 0, 0, 0, 0), 1'b1,
			'{status: ST_OK, symbol_ready: 1'b1, symbol: 8'hFF}});
		rows.push_back('{mk(OP_DECODE, 0, 0, 0, 1), 1'b1,
			'{status: ST_NO_CODE, symbol_ready: 1'b0, symbol: 8'd0}});
		rows.push_back('{mk(OP_LOAD_COUNT, 2, 4, 0, 0), 1'b0, okr});
		for (int i = 0; i < 4; i++)
			rows.push_back('{mk(OP_APPEND, 0, 0, 8'h10 + i, 0), 1'b0, okr});
		rows.push_back('{mk(OP_BUILD, 0, 0, 0, 0), 1'b0, okr});
		rows.push_back('{mk(OP_DECODE, 0, 0, 0, 1), 1'b0, okr});
		rows.push_back('{mk(OP_DECODE, 0, 0, 0, 1), 1'b0, okr});
		// empty code: every bit has no code
		rows.push_back('{mk(OP_BUILD, 0, 0, 0, 0), 1'b1, okr});
		rows.push_back('{mk(OP_DECODE, 0, 0, 0, 0), 1'b1,
			'{status: ST_NO_CODE, symbol_ready: 1'b0, symbol: 8'd0}});

		foreach (rows[i])
			send_item(rows[i].it, rows[i].fixed, rows[i].res);

		// staging full: 257 appends, then a build with more codes than symbols and one that commits all 256
		for (int i = 0; i <= MaxSymbols; i++)
			stim_q.push_back(mk(OP_APPEND, 0, 0, $urandom_range(0, 255), 0));
		stim_q.push_back(mk(OP_LOAD_COUNT, 8, 255, 0, 0));
		stim_q.push_back(mk(OP_LOAD_COUNT, 9, 2, 0, 0));
		stim_q.push_back(mk(OP_BUILD, 0, 0, 0, 0));
		stim_q.push_back(mk(OP_LOAD_COUNT, 9, 0, 0, 0));
		stim_q.push_back(mk(OP_LOAD_COUNT, 16, 1, 0, 0));
		stim_q.push_back(mk(OP_BUILD, 0, 0, 0, 0));
		stim_q.push_back(mk(OP_LOAD_COUNT, 8, 0, 0, 0));
		stim_q.push_back(mk(OP_LOAD_COUNT, 16, 0, 0, 0));

		// random phases with different idling
		for (int ph = 0; ph < 4; ph++) begin
			in_idle_pct = (ph == 1) ? 49 : (ph == 3) ? 34 : 0;
			out_stall_pct = (ph == 2) ? 49 : (ph == 3) ? 34 : 0;
			while (stim_q.size() < 40) begin
				if ($urandom_range(0, 5) == 0)
					stim_q.push_back(noise_item());
				else
					queue_table();
			end
			while (stim_q.size() > 0)
				send_item(stim_q.pop_front(), 1'b0, okr);
		end
		in_ch.valid <= 1'b0;
		out_stall_pct = 0;

		while (expected_q.size() > 0)
			@(posedge clk);
		repeat (30) @(posedge clk);

		$display("sent %0d items, checked %0d results, %0d decoded symbols", sent_count,
			checked_count, symbol_count);
		if (fail_count == 0 && expected_q.size() == 0)
			$display("canonical_huffman_bit_decoder_test passed");
		else
			$display("canonical_huffman_bit_decoder_test failed");
		$finish;
	end
endmodule
`default_nettype wire

>>> sim.f
rtl/chbd_pkg.sv
rtl/chbd_in_if.sv
rtl/chbd_out_if.sv
rtl/chbd_ram.sv
rtl/chbd_ctrl.sv
rtl/chbd_dp.sv
rtl/canonical_huffman_bit_decoder.sv
bench/canonical_huffman_bit_decoder_test.sv
